// ===== hdl/fvds_pkg.sv =====
package fvds_pkg;

  localparam int COORD_W    = 32;
  localparam int DIFF_W     = COORD_W + 1;
  localparam int DV_W       = COORD_W + 3;
  localparam int N_W        = 2 * DIFF_W + 1;
  localparam int NSQ_W      = 2 * N_W + 2;
  localparam int DSQ_W      = 2 * DV_W + 2;
  localparam int NDP_W      = N_W + DV_W;
  localparam int DOT_W      = NDP_W + 2;

  localparam int OUT_FRAC   = 16;
  localparam int INT_W      = OUT_FRAC + 1;
  localparam int QUO_W      = 2 * OUT_FRAC + 1;
  localparam int R_W        = NSQ_W + DSQ_W;
  localparam int L_W        = R_W + 2 * OUT_FRAC;

  localparam int MUL_LIMB_W  = 32;
  localparam int MUL_LIMBS   = 5;
  localparam int MUL_W       = MUL_LIMB_W * MUL_LIMBS;
  localparam int PROD_W      = 2 * MUL_W;
  localparam int TREE_LVLS   = $clog2(MUL_LIMBS);
  localparam int TREE_LEAVES = 1 << TREE_LVLS;
  localparam int MUL_LAT     = 2 + TREE_LVLS;

  localparam int GEO_LAT    = 5 + 2 * MUL_LAT;
  localparam int RAT_LAT    = 1 + MUL_LAT + QUO_W;
  localparam int SQ_LAT     = INT_W + 1;
  localparam int TOTAL_LAT  = GEO_LAT + RAT_LAT + SQ_LAT;

  localparam int CFG_DATA_W = 32;
  localparam int ADDR_W     = 4;
  localparam logic [1:0] REG_EYE_X = 2'd0;
  localparam logic [1:0] REG_EYE_Y = 2'd1;
  localparam logic [1:0] REG_EYE_Z = 2'd2;

  typedef struct packed {
    logic normal_degenerate;
    logic eye_on_center;
  } flags_t;

endpackage

// ===== hdl/fvds_mul.sv =====
module fvds_mul (
  input  logic                        clk,
  input  logic                        en,
  input  logic [fvds_pkg::MUL_W-1:0]  a,
  input  logic [fvds_pkg::MUL_W-1:0]  b,
  input  logic                        neg,
  output logic [fvds_pkg::PROD_W-1:0] p,
  output logic                        p_neg
);
  import fvds_pkg::*;

  logic [2*MUL_LIMB_W-1:0] pp_r [MUL_LIMBS][MUL_LIMBS];
  logic [PROD_W-1:0]       row_even [MUL_LIMBS];
  logic [PROD_W-1:0]       row_odd  [MUL_LIMBS];
  logic [PROD_W-1:0]       node_r   [1:2*TREE_LEAVES-1];
  logic [MUL_LAT-1:0]      neg_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < MUL_LIMBS; i++) begin
        for (int j = 0; j < MUL_LIMBS; j++) begin
          pp_r[i][j] <= (2*MUL_LIMB_W)'(a[i*MUL_LIMB_W +: MUL_LIMB_W])
                      * (2*MUL_LIMB_W)'(b[j*MUL_LIMB_W +: MUL_LIMB_W]);
        end
      end
    end
  end

  // Partial products of even and odd columns do not overlap, so each row
  // collapses into a single add.
  always_comb begin
    for (int i = 0; i < MUL_LIMBS; i++) begin
      row_even[i] = '0;
      row_odd[i]  = '0;
      for (int j = 0; j < MUL_LIMBS; j++) begin
        if ((j & 1) == 0) begin
          row_even[i] = row_even[i] | (PROD_W'(pp_r[i][j]) << (MUL_LIMB_W * (i + j)));
        end else begin
          row_odd[i]  = row_odd[i]  | (PROD_W'(pp_r[i][j]) << (MUL_LIMB_W * (i + j)));
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < MUL_LIMBS; k++) begin
        node_r[TREE_LEAVES+k] <= row_even[k] + row_odd[k];
      end
      for (int k = MUL_LIMBS; k < TREE_LEAVES; k++) begin
        node_r[TREE_LEAVES+k] <= '0;
      end
      for (int k = 1; k < TREE_LEAVES; k++) begin
        node_r[k] <= node_r[2*k] + node_r[2*k+1];
      end
      neg_r <= {neg_r[MUL_LAT-2:0], neg};
    end
  end

  assign p     = node_r[1];
  assign p_neg = neg_r[MUL_LAT-1];

endmodule

// ===== hdl/fvds_geom.sv =====
module fvds_geom (
  input  logic                               clk,
  input  logic                               en,
  input  logic signed [fvds_pkg::COORD_W-1:0] v0_x,
  input  logic signed [fvds_pkg::COORD_W-1:0] v0_y,
  input  logic signed [fvds_pkg::COORD_W-1:0] v0_z,
  input  logic signed [fvds_pkg::COORD_W-1:0] v1_x,
  input  logic signed [fvds_pkg::COORD_W-1:0] v1_y,
  input  logic signed [fvds_pkg::COORD_W-1:0] v1_z,
  input  logic signed [fvds_pkg::COORD_W-1:0] v2_x,
  input  logic signed [fvds_pkg::COORD_W-1:0] v2_y,
  input  logic signed [fvds_pkg::COORD_W-1:0] v2_z,
  input  logic signed [fvds_pkg::COORD_W-1:0] eye_x,
  input  logic signed [fvds_pkg::COORD_W-1:0] eye_y,
  input  logic signed [fvds_pkg::COORD_W-1:0] eye_z,
  output logic        [fvds_pkg::NSQ_W-1:0]   n2,
  output logic        [fvds_pkg::DSQ_W-1:0]   d2,
  output logic signed [fvds_pkg::DOT_W-1:0]   dot,
  output fvds_pkg::flags_t                    flags
);
  import fvds_pkg::*;

  logic signed [COORD_W-1:0] v0 [3];
  logic signed [COORD_W-1:0] v1 [3];
  logic signed [COORD_W-1:0] v2 [3];
  logic signed [COORD_W-1:0] eye [3];

  logic signed [DIFF_W-1:0] ea_r [3];
  logic signed [DIFF_W-1:0] eb_r [3];
  logic signed [DV_W-1:0]   dv_r [3];

  logic [DIFF_W-1:0] xa_mag_r [6];
  logic [DIFF_W-1:0] xb_mag_r [6];
  logic              xneg_r   [6];
  logic [DV_W-1:0]   dvmag_r  [3];
  logic              dvneg_r  [3];

  logic [DV_W-1:0]   dvm_d_r [MUL_LAT+1][3];
  logic              dvn_d_r [MUL_LAT+1][3];

  logic [PROD_W-1:0] px_p   [6];
  logic              px_neg [6];

  logic signed [N_W-1:0] n_r [3];

  logic [N_W-1:0]  nmag_r  [3];
  logic [DV_W-1:0] dvm4_r  [3];
  logic            ndneg_r [3];
  flags_t          flg4_r;
  flags_t          fd_r [MUL_LAT];

  logic [PROD_W-1:0] pnn [3];
  logic [PROD_W-1:0] pdd [3];
  logic [PROD_W-1:0] pnd [3];
  logic              pnd_neg [3];

  logic [NSQ_W-1:0]        n2_r;
  logic [DSQ_W-1:0]        d2_r;
  logic signed [DOT_W-1:0] dot_r;
  flags_t                  flg5_r;

  assign v0  = '{v0_x, v0_y, v0_z};
  assign v1  = '{v1_x, v1_y, v1_z};
  assign v2  = '{v2_x, v2_y, v2_z};
  assign eye = '{eye_x, eye_y, eye_z};

  // Edges and the view direction, with the centroid scaled by three.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int a = 0; a < 3; a++) begin
        ea_r[a] <= DIFF_W'(v0[a]) - DIFF_W'(v1[a]);
        eb_r[a] <= DIFF_W'(v1[a]) - DIFF_W'(v2[a]);
        dv_r[a] <= DV_W'(v0[a]) + DV_W'(v1[a]) + DV_W'(v2[a])
                 - DV_W'(eye[a]) - (DV_W'(eye[a]) <<< 1);
      end
    end
  end

  // Cross product terms go to the multipliers as magnitude and sign.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int a = 0; a < 3; a++) begin
        xa_mag_r[2*a]   <= ea_r[(a+1)%3][DIFF_W-1] ? DIFF_W'(-ea_r[(a+1)%3])
                                                   : DIFF_W'(ea_r[(a+1)%3]);
        xb_mag_r[2*a]   <= eb_r[(a+2)%3][DIFF_W-1] ? DIFF_W'(-eb_r[(a+2)%3])
                                                   : DIFF_W'(eb_r[(a+2)%3]);
        xneg_r[2*a]     <= ea_r[(a+1)%3][DIFF_W-1] ^ eb_r[(a+2)%3][DIFF_W-1];
        xa_mag_r[2*a+1] <= ea_r[(a+2)%3][DIFF_W-1] ? DIFF_W'(-ea_r[(a+2)%3])
                                                   : DIFF_W'(ea_r[(a+2)%3]);
        xb_mag_r[2*a+1] <= eb_r[(a+1)%3][DIFF_W-1] ? DIFF_W'(-eb_r[(a+1)%3])
                                                   : DIFF_W'(eb_r[(a+1)%3]);
        xneg_r[2*a+1]   <= ea_r[(a+2)%3][DIFF_W-1] ^ eb_r[(a+1)%3][DIFF_W-1];
        dvmag_r[a]      <= dv_r[a][DV_W-1] ? DV_W'(-dv_r[a]) : DV_W'(dv_r[a]);
        dvneg_r[a]      <= dv_r[a][DV_W-1];
      end
    end
  end

  for (genvar m = 0; m < 6; m++) begin : g_xmul
    fvds_mul u_mul (
      .clk   (clk),
      .en    (en),
      .a     (MUL_W'(xa_mag_r[m])),
      .b     (MUL_W'(xb_mag_r[m])),
      .neg   (xneg_r[m]),
      .p     (px_p[m]),
      .p_neg (px_neg[m])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dvm_d_r[0] <= dvmag_r;
      dvn_d_r[0] <= dvneg_r;
      for (int k = 1; k <= MUL_LAT; k++) begin
        dvm_d_r[k] <= dvm_d_r[k-1];
        dvn_d_r[k] <= dvn_d_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int a = 0; a < 3; a++) begin
        n_r[a] <= (px_neg[2*a] ? -N_W'(px_p[2*a][2*DIFF_W-1:0])
                               :  N_W'(px_p[2*a][2*DIFF_W-1:0]))
                - (px_neg[2*a+1] ? -N_W'(px_p[2*a+1][2*DIFF_W-1:0])
                                 :  N_W'(px_p[2*a+1][2*DIFF_W-1:0]));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int a = 0; a < 3; a++) begin
        nmag_r[a]  <= n_r[a][N_W-1] ? N_W'(-n_r[a]) : N_W'(n_r[a]);
        dvm4_r[a]  <= dvm_d_r[MUL_LAT][a];
        ndneg_r[a] <= n_r[a][N_W-1] ^ dvn_d_r[MUL_LAT][a];
      end
      flg4_r.normal_degenerate <= (n_r[0] == '0) && (n_r[1] == '0) && (n_r[2] == '0);
      flg4_r.eye_on_center     <= (dvm_d_r[MUL_LAT][0] == '0) &&
                                  (dvm_d_r[MUL_LAT][1] == '0) &&
                                  (dvm_d_r[MUL_LAT][2] == '0);
      fd_r[0] <= flg4_r;
      for (int k = 1; k < MUL_LAT; k++) begin
        fd_r[k] <= fd_r[k-1];
      end
    end
  end

  for (genvar a = 0; a < 3; a++) begin : g_smul
    fvds_mul u_nn (
      .clk   (clk),
      .en    (en),
      .a     (MUL_W'(nmag_r[a])),
      .b     (MUL_W'(nmag_r[a])),
      .neg   (1'b0),
      .p     (pnn[a]),
      .p_neg ()
    );
    fvds_mul u_dd (
      .clk   (clk),
      .en    (en),
      .a     (MUL_W'(dvm4_r[a])),
      .b     (MUL_W'(dvm4_r[a])),
      .neg   (1'b0),
      .p     (pdd[a]),
      .p_neg ()
    );
    fvds_mul u_nd (
      .clk   (clk),
      .en    (en),
      .a     (MUL_W'(nmag_r[a])),
      .b     (MUL_W'(dvm4_r[a])),
      .neg   (ndneg_r[a]),
      .p     (pnd[a]),
      .p_neg (pnd_neg[a])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n2_r  <= NSQ_W'(pnn[0][2*N_W-1:0]) + NSQ_W'(pnn[1][2*N_W-1:0])
             + NSQ_W'(pnn[2][2*N_W-1:0]);
      d2_r  <= DSQ_W'(pdd[0][2*DV_W-1:0]) + DSQ_W'(pdd[1][2*DV_W-1:0])
             + DSQ_W'(pdd[2][2*DV_W-1:0]);
      dot_r <= (pnd_neg[0] ? -DOT_W'(pnd[0][NDP_W-1:0]) : DOT_W'(pnd[0][NDP_W-1:0]))
             + (pnd_neg[1] ? -DOT_W'(pnd[1][NDP_W-1:0]) : DOT_W'(pnd[1][NDP_W-1:0]))
             + (pnd_neg[2] ? -DOT_W'(pnd[2][NDP_W-1:0]) : DOT_W'(pnd[2][NDP_W-1:0]));
      flg5_r <= fd_r[MUL_LAT-1];
    end
  end

  assign n2    = n2_r;
  assign d2    = d2_r;
  assign dot   = dot_r;
  assign flags = flg5_r;

endmodule

// ===== hdl/fvds_ratio.sv =====
module fvds_ratio (
  input  logic                              clk,
  input  logic                              en,
  input  logic        [fvds_pkg::NSQ_W-1:0] n2,
  input  logic        [fvds_pkg::DSQ_W-1:0] d2,
  input  logic signed [fvds_pkg::DOT_W-1:0] dot,
  input  fvds_pkg::flags_t                  flags_in,
  output logic        [fvds_pkg::QUO_W-1:0] quo,
  output fvds_pkg::flags_t                  flags_out
);
  import fvds_pkg::*;

  logic [DOT_W-1:0] dotmag_r;
  logic [NSQ_W-1:0] n2_r;
  logic [DSQ_W-1:0] d2_r;
  flags_t           flg1_r;
  flags_t           fd_r [MUL_LAT];

  logic [PROD_W-1:0] p_dd;
  logic [PROD_W-1:0] p_nd;
  logic [L_W-1:0]    l_val;
  logic [R_W-1:0]    r_val;

  logic [L_W-1:0]   rem_r [QUO_W];
  logic [R_W-1:0]   den_r [QUO_W];
  logic [QUO_W-1:0] quo_r [QUO_W];
  flags_t           flg_r [QUO_W];

  always_ff @(posedge clk) begin
    if (en) begin
      dotmag_r <= dot[DOT_W-1] ? DOT_W'(-dot) : DOT_W'(dot);
      n2_r     <= n2;
      d2_r     <= d2;
      flg1_r   <= flags_in;
      fd_r[0]  <= flg1_r;
      for (int k = 1; k < MUL_LAT; k++) begin
        fd_r[k] <= fd_r[k-1];
      end
    end
  end

  fvds_mul u_dot_sq (
    .clk   (clk),
    .en    (en),
    .a     (MUL_W'(dotmag_r)),
    .b     (MUL_W'(dotmag_r)),
    .neg   (1'b0),
    .p     (p_dd),
    .p_neg ()
  );

  fvds_mul u_len_sq (
    .clk   (clk),
    .en    (en),
    .a     (MUL_W'(n2_r)),
    .b     (MUL_W'(d2_r)),
    .neg   (1'b0),
    .p     (p_nd),
    .p_neg ()
  );

  // cos^2 scaled by 2^32 is at most 2^32, so the quotient fits in QUO_W bits.
  assign l_val = {p_dd[L_W-2*OUT_FRAC-1:0], (2*OUT_FRAC)'(0)};
  assign r_val = p_nd[R_W-1:0];

  for (genvar s = 0; s < QUO_W; s++) begin : g_div
    localparam int BIT = QUO_W - 1 - s;
    logic [L_W-1:0]   rem_in;
    logic [R_W-1:0]   den_in;
    logic [QUO_W-1:0] quo_in;
    flags_t           flg_in;
    logic [L_W:0]     trial;

    if (s == 0) begin : g_first
      assign rem_in = l_val;
      assign den_in = r_val;
      assign quo_in = '0;
      assign flg_in = fd_r[MUL_LAT-1];
    end else begin : g_next
      assign rem_in = rem_r[s-1];
      assign den_in = den_r[s-1];
      assign quo_in = quo_r[s-1];
      assign flg_in = flg_r[s-1];
    end

    assign trial = {1'b0, rem_in} - ((L_W+1)'(den_in) << BIT);

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s] <= trial[L_W] ? rem_in : trial[L_W-1:0];
        den_r[s] <= den_in;
        quo_r[s] <= trial[L_W] ? quo_in : (quo_in | (QUO_W'(1) << BIT));
        flg_r[s] <= flg_in;
      end
    end
  end

  assign quo       = quo_r[QUO_W-1];
  assign flags_out = flg_r[QUO_W-1];

endmodule

// ===== hdl/fvds_isqrt.sv =====
module fvds_isqrt (
  input  logic                       clk,
  input  logic                       en,
  input  logic [fvds_pkg::QUO_W-1:0] rad,
  input  fvds_pkg::flags_t           flags_in,
  output logic [fvds_pkg::INT_W-1:0] intensity,
  output fvds_pkg::flags_t           flags_out
);
  import fvds_pkg::*;

  logic [INT_W-1:0] q_r   [INT_W];
  logic [QUO_W-1:0] rad_r [INT_W];
  flags_t           flg_r [INT_W];
  logic [INT_W-1:0] int_r;
  flags_t           fout_r;

  for (genvar s = 0; s < INT_W; s++) begin : g_root
    localparam int BIT = INT_W - 1 - s;
    logic [INT_W-1:0]   q_in;
    logic [QUO_W-1:0]   rad_in;
    flags_t             flg_in;
    logic [INT_W-1:0]   cand;
    logic [2*INT_W-1:0] cand_sq;

    if (s == 0) begin : g_first
      assign q_in   = '0;
      assign rad_in = rad;
      assign flg_in = flags_in;
    end else begin : g_next
      assign q_in   = q_r[s-1];
      assign rad_in = rad_r[s-1];
      assign flg_in = flg_r[s-1];
    end

    assign cand    = q_in | (INT_W'(1) << BIT);
    assign cand_sq = (2*INT_W)'(cand) * (2*INT_W)'(cand);

    always_ff @(posedge clk) begin
      if (en) begin
        q_r[s]   <= (cand_sq <= (2*INT_W)'(rad_in)) ? cand : q_in;
        rad_r[s] <= rad_in;
        flg_r[s] <= flg_in;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      int_r  <= (flg_r[INT_W-1].normal_degenerate || flg_r[INT_W-1].eye_on_center)
              ? '0 : q_r[INT_W-1];
      fout_r <= flg_r[INT_W-1];
    end
  end

  assign intensity = int_r;
  assign flags_out = fout_r;

endmodule

// ===== hdl/facet_view_diffuse_shading_core.sv =====
// Throughput: one triangle per cycle while the skid buffer is empty; the depth
// comes from the 32-bit limb multiplier trees, the 33-step restoring divider
// and the 17-step square root.
// A stalled result moves into a one-entry skid buffer; the pipeline then holds.
// Reset clears the valid bits, the skid buffer's full flag and the eye registers to zero.
module facet_view_diffuse_shading_core (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [fvds_pkg::COORD_W-1:0]    in_v0_x,
  input  logic signed [fvds_pkg::COORD_W-1:0]    in_v0_y,
  input  logic signed [fvds_pkg::COORD_W-1:0]    in_v0_z,
  input  logic signed [fvds_pkg::COORD_W-1:0]    in_v1_x,
  input  logic signed [fvds_pkg::COORD_W-1:0]    in_v1_y,
  input  logic signed [fvds_pkg::COORD_W-1:0]    in_v1_z,
  input  logic signed [fvds_pkg::COORD_W-1:0]    in_v2_x,
  input  logic signed [fvds_pkg::COORD_W-1:0]    in_v2_y,
  input  logic signed [fvds_pkg::COORD_W-1:0]    in_v2_z,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic        [fvds_pkg::INT_W-1:0]      out_intensity,
  output logic                                   out_normal_degenerate,
  output logic                                   out_eye_on_center,
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic        [fvds_pkg::ADDR_W-1:0]     paddr,
  input  logic        [fvds_pkg::CFG_DATA_W-1:0] pwdata,
  output logic        [fvds_pkg::CFG_DATA_W-1:0] prdata,
  output logic                                   pready
);
  import fvds_pkg::*;

  logic signed [COORD_W-1:0] eye_x_r, eye_y_r, eye_z_r;
  logic [TOTAL_LAT-1:0]      vld_r;
  logic                      en;

  logic [NSQ_W-1:0]        g_n2;
  logic [DSQ_W-1:0]        g_d2;
  logic signed [DOT_W-1:0] g_dot;
  flags_t                  g_flags;
  logic [QUO_W-1:0]        r_quo;
  flags_t                  r_flags;
  logic [INT_W-1:0]        s_int;
  flags_t                  s_flags;

  logic             skid_full_r;
  logic [INT_W-1:0] skid_int_r;
  flags_t           skid_flg_r;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eye_x_r <= '0;
      eye_y_r <= '0;
      eye_z_r <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        REG_EYE_X: eye_x_r <= pwdata;
        REG_EYE_Y: eye_y_r <= pwdata;
        REG_EYE_Z: eye_z_r <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_EYE_X: prdata = eye_x_r;
      REG_EYE_Y: prdata = eye_y_r;
      REG_EYE_Z: prdata = eye_z_r;
      default:   prdata = '0;
    endcase
  end

  // The whole pipeline holds only while the skid buffer is occupied.
  assign en       = !skid_full_r;
  assign in_stall = skid_full_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[TOTAL_LAT-2:0], in_valid};
    end
  end

  fvds_geom u_geom (
    .clk   (clk),
    .en    (en),
    .v0_x  (in_v0_x),
    .v0_y  (in_v0_y),
    .v0_z  (in_v0_z),
    .v1_x  (in_v1_x),
    .v1_y  (in_v1_y),
    .v1_z  (in_v1_z),
    .v2_x  (in_v2_x),
    .v2_y  (in_v2_y),
    .v2_z  (in_v2_z),
    .eye_x (eye_x_r),
    .eye_y (eye_y_r),
    .eye_z (eye_z_r),
    .n2    (g_n2),
    .d2    (g_d2),
    .dot   (g_dot),
    .flags (g_flags)
  );

  fvds_ratio u_ratio (
    .clk       (clk),
    .en        (en),
    .n2        (g_n2),
    .d2        (g_d2),
    .dot       (g_dot),
    .flags_in  (g_flags),
    .quo       (r_quo),
    .flags_out (r_flags)
  );

  fvds_isqrt u_isqrt (
    .clk       (clk),
    .en        (en),
    .rad       (r_quo),
    .flags_in  (r_flags),
    .intensity (s_int),
    .flags_out (s_flags)
  );

  // A stalled result moves into the skid buffer so the pipeline can take
  // one more transaction.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skid_full_r <= 1'b0;
    end else if (skid_full_r) begin
      if (!out_stall) skid_full_r <= 1'b0;
    end else if (vld_r[TOTAL_LAT-1] && out_stall) begin
      skid_full_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      skid_int_r <= s_int;
      skid_flg_r <= s_flags;
    end
  end

  assign out_valid             = skid_full_r || vld_r[TOTAL_LAT-1];
  assign out_intensity         = skid_full_r ? skid_int_r : s_int;
  assign out_normal_degenerate = skid_full_r ? skid_flg_r.normal_degenerate
                                             : s_flags.normal_degenerate;
  assign out_eye_on_center     = skid_full_r ? skid_flg_r.eye_on_center
                                             : s_flags.eye_on_center;

endmodule

// ===== hdl/fvds_checker.sv =====
module fvds_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_stall,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [fvds_pkg::INT_W-1:0] out_intensity,
  input logic                       out_normal_degenerate,
  input logic                       out_eye_on_center
);
  import fvds_pkg::*;

  localparam logic [INT_W-1:0] FULL_SCALE = INT_W'(1) << OUT_FRAC;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_intensity))
    else $error("stalled result changed");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_intensity <= FULL_SCALE)
    else $error("intensity above full scale");

  a_flag_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_normal_degenerate || out_eye_on_center) |-> out_intensity == '0)
    else $error("flagged result with nonzero intensity");

  a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && $past(out_valid && out_stall))
    else $error("input stalled without a waiting result");

endmodule

bind facet_view_diffuse_shading_core fvds_checker u_fvds_checker (.*);
